// ===== rtl/ffa_pkg.sv =====
// Package for the first-fit arena allocator: sizes, header layout,
// opcodes and status codes. No dependencies.
package ffa_pkg;

  localparam int ARENA_BYTES  = 8192;
  localparam int MAX_ARENAS   = 4;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;
  localparam int SPLIT_SPARE  = HEADER_BYTES * 2;
  localparam int FULL_SIZE    = ARENA_BYTES - HEADER_BYTES;

  localparam int OFF_W   = $clog2(ARENA_BYTES);
  localparam int AR_W    = $clog2(MAX_ARENAS);
  localparam int ALIGN_W = $clog2(ALIGN_BYTES);
  localparam int SLOT_W  = OFF_W - ALIGN_W;
  localparam int ADDR_W  = AR_W + SLOT_W;
  localparam int HDR_SLOTS = HEADER_BYTES / ALIGN_BYTES;
  localparam int LIMIT_W = OFF_W + 1;
  localparam int OPEN_W  = $clog2(MAX_ARENAS + 1);
  localparam int HDR_DEPTH = MAX_ARENAS * (ARENA_BYTES / ALIGN_BYTES);

  typedef struct packed {
    logic [OFF_W-1:0]  size;
    logic              is_free;
    logic              has_link;
    logic [SLOT_W-1:0] link;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/first_fit_arena_allocator.sv =====
// First-fit arena allocator top level: request sequencer over the header RAM.
// Depends on ffa_pkg and ffa_ram.

// One request at a time. Block headers live in one RAM with a registered
// read; every header access is a read or a write of that single port pair,
// so the time a request takes follows the list walks. Allocate searches
// the open arenas, visiting each free-list entry in turn, and then takes
// the block. Free checks the header, then walks each list entry in the
// outer merge pass, with inner steps and a merge on each match. Each walk
// stops after ARENA_BYTES steps. Reallocate adds one header read and, on
// a move, an allocate followed by a free. A result may wait in the output
// register; the next request is taken once the sequencer is back in idle.
module first_fit_arena_allocator
  import ffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [15:0]       request_size,
  input  logic              pointer_present,
  input  logic [AR_W-1:0]   arena_index,
  input  logic [OFF_W-1:0]  payload_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [AR_W-1:0]   result_arena,
  output logic [OFF_W-1:0]  result_offset,
  output logic [OFF_W-1:0]  copy_bytes
);

  localparam int NS = 23;
  typedef enum logic [NS-1:0] {
    S_IDLE     = NS'(1) << 0,
    S_DECODE   = NS'(1) << 1,
    S_RE_OLD   = NS'(1) << 2,
    S_ALLOC    = NS'(1) << 3,
    S_ARENA    = NS'(1) << 4,
    S_WINIT    = NS'(1) << 5,
    S_WTEST    = NS'(1) << 6,
    S_WREAD    = NS'(1) << 7,
    S_TAKE_B   = NS'(1) << 8,
    S_TLINK    = NS'(1) << 9,
    S_TPREV    = NS'(1) << 10,
    S_AOK      = NS'(1) << 11,
    S_FCHECK   = NS'(1) << 12,
    S_FREAD    = NS'(1) << 13,
    S_OTEST    = NS'(1) << 14,
    S_OREAD    = NS'(1) << 15,
    S_ITEST    = NS'(1) << 16,
    S_IREAD    = NS'(1) << 17,
    S_MERGE_C  = NS'(1) << 18,
    S_MERGE_SR = NS'(1) << 19,
    S_MERGE_S  = NS'(1) << 20,
    S_ONEXT    = NS'(1) << 21,
    S_FINISH   = NS'(1) << 22
  } state_t;

  state_t state;

  // latched request
  logic [1:0]       op_r;
  logic             pp_r;
  logic [AR_W-1:0]  ar_r;
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] need;
  logic             size_zero;
  logic             too_big;
  logic             move;

  // allocator state
  logic [SLOT_W-1:0] heads [MAX_ARENAS];
  logic [MAX_ARENAS-1:0] head_valid;
  logic [OPEN_W-1:0] arenas_open;

  // walk registers
  logic [AR_W-1:0]    cur_ar;
  logic [OPEN_W-1:0]  ar_cnt;
  logic               opened;
  logic [SLOT_W-1:0]  cur, prev, r_slot, slot, nx, new_link, n_link;
  logic               cv, pv, nv, new_has, n_has;
  logic [LIMIT_W-1:0] steps, in_steps;
  logic [SLOT_W:0]    end_slot;
  logic [OFF_W-1:0]   n_size, old_size;

  // result
  logic [2:0]       res_status;
  logic [AR_W-1:0]  res_ar;
  logic [OFF_W-1:0] res_off, res_cb;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  hdr_t              ram_wdata, rd_hdr;
  logic [HDR_W-1:0]  ram_rdata;

  assign rd_hdr = hdr_t'(ram_rdata);

  ffa_ram #(
    .WIDTH(HDR_W),
    .DEPTH(HDR_DEPTH)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(HDR_W'(ram_wdata)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [16:0]       need_in;
  logic              ptr_ok;
  logic [SLOT_W-1:0] h_slot;
  logic              fits, split, match;
  logic [OFF_W:0]    split_need;

  assign need_in = (17'(request_size) + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
  assign ptr_ok = ({{(OPEN_W-AR_W){1'b0}}, ar_r} < arenas_open)
               && (off_r >= OFF_W'(HEADER_BYTES))
               && (off_r[ALIGN_W-1:0] == '0);
  assign h_slot = off_r[OFF_W-1:ALIGN_W] - SLOT_W'(HDR_SLOTS);
  assign split_need = {1'b0, need} + (OFF_W+1)'(SPLIT_SPARE);
  assign fits  = rd_hdr.is_free && (rd_hdr.size >= need);
  assign split = {1'b0, rd_hdr.size} >= split_need;
  assign match = ({1'b0, nx} == end_slot);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;
    case (state)
      S_DECODE: begin
        ram_raddr = {ar_r, h_slot};
        ram_re = (op_r == OP_REALLOC) && pp_r && ptr_ok && !size_zero;
      end
      S_ARENA: begin
        ram_waddr = {arenas_open[AR_W-1:0], {SLOT_W{1'b0}}};
        ram_wdata = '{size: OFF_W'(FULL_SIZE), is_free: 1'b1, has_link: 1'b0, link: '0};
        ram_we = (ar_cnt == '0) && (arenas_open < OPEN_W'(MAX_ARENAS));
      end
      S_WTEST: begin
        ram_raddr = {cur_ar, cur};
        ram_re = cv && !steps[LIMIT_W-1];
      end
      S_WREAD: begin
        if (fits && split) begin
          ram_waddr = {cur_ar, cur + SLOT_W'(HDR_SLOTS) + need[OFF_W-1:ALIGN_W]};
          ram_wdata = '{size: rd_hdr.size - need - OFF_W'(HEADER_BYTES), is_free: 1'b1,
                        has_link: rd_hdr.has_link, link: rd_hdr.link};
        end else begin
          ram_waddr = {cur_ar, cur};
          ram_wdata = '{size: rd_hdr.size, is_free: 1'b0,
                        has_link: rd_hdr.has_link, link: rd_hdr.link};
        end
        ram_we = fits;
      end
      S_TAKE_B: begin
        ram_waddr = {cur_ar, cur};
        ram_wdata = '{size: need, is_free: 1'b0, has_link: 1'b1, link: r_slot};
        ram_we = 1'b1;
      end
      S_TLINK: begin
        ram_raddr = {cur_ar, prev};
        ram_re = pv;
      end
      S_TPREV: begin
        ram_waddr = {cur_ar, prev};
        ram_wdata = '{size: rd_hdr.size, is_free: rd_hdr.is_free,
                      has_link: new_has, link: new_link};
        ram_we = 1'b1;
      end
      S_FCHECK: begin
        ram_raddr = {ar_r, h_slot};
        ram_re = ptr_ok;
      end
      S_FREAD: begin
        ram_waddr = {cur_ar, h_slot};
        ram_wdata = '{size: rd_hdr.size, is_free: 1'b1,
                      has_link: head_valid[cur_ar], link: heads[cur_ar]};
        ram_we = !rd_hdr.is_free;
      end
      S_OTEST: begin
        ram_raddr = {cur_ar, cur};
        ram_re = cv && !steps[LIMIT_W-1];
      end
      S_ITEST: begin
        if (nv && !in_steps[LIMIT_W-1]) begin
          ram_raddr = {cur_ar, nx};
        end else begin
          ram_raddr = {cur_ar, cur};
        end
        ram_re = 1'b1;
      end
      S_IREAD: begin
        ram_raddr = {cur_ar, cur};
        ram_re = match;
      end
      S_MERGE_C: begin
        ram_waddr = {cur_ar, cur};
        ram_wdata = '{size: rd_hdr.size + n_size + OFF_W'(HEADER_BYTES),
                      is_free: rd_hdr.is_free, has_link: rd_hdr.has_link, link: rd_hdr.link};
        ram_we = 1'b1;
      end
      S_MERGE_SR: begin
        ram_raddr = {cur_ar, slot};
        ram_re = 1'b1;
      end
      S_MERGE_S: begin
        ram_waddr = {cur_ar, slot};
        ram_wdata = '{size: rd_hdr.size, is_free: rd_hdr.is_free,
                      has_link: n_has, link: n_link};
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      head_valid  <= '0;
      arenas_open <= '0;
      move        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= opcode;
            pp_r       <= pointer_present;
            ar_r       <= arena_index;
            off_r      <= payload_offset;
            need       <= need_in[OFF_W-1:0];
            size_zero  <= (request_size == '0);
            too_big    <= (need_in > 17'(FULL_SIZE));
            move       <= 1'b0;
            res_status <= ST_NULL;
            res_ar     <= '0;
            res_off    <= '0;
            res_cb     <= '0;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (op_r)
            OP_ALLOC: state <= S_ALLOC;
            OP_FREE:  state <= pp_r ? S_FCHECK : S_FINISH;
            OP_REALLOC: begin
              if (!pp_r) begin
                state <= S_ALLOC;
              end else if (!ptr_ok) begin
                res_status <= ST_INVALID;
                state <= S_FINISH;
              end else if (size_zero) begin
                state <= S_FCHECK;
              end else begin
                state <= S_RE_OLD;
              end
            end
            default: state <= S_FINISH;
          endcase
        end
        S_RE_OLD: begin
          old_size <= rd_hdr.size;
          // need may be truncated when the request is oversized
          if (!too_big && need <= rd_hdr.size) begin
            res_status <= ST_OK;
            res_ar     <= ar_r;
            res_off    <= off_r;
            state      <= S_FINISH;
          end else begin
            move  <= 1'b1;
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          ar_cnt <= arenas_open;
          opened <= 1'b0;
          state  <= (size_zero || too_big) ? S_FINISH : S_ARENA;
        end
        S_ARENA: begin
          if (ar_cnt != '0) begin
            cur_ar <= AR_W'(ar_cnt - OPEN_W'(1));
            ar_cnt <= ar_cnt - OPEN_W'(1);
            state  <= S_WINIT;
          end else if (arenas_open >= OPEN_W'(MAX_ARENAS)) begin
            state <= S_FINISH;
          end else begin
            cur_ar <= arenas_open[AR_W-1:0];
            heads[arenas_open[AR_W-1:0]]      <= '0;
            head_valid[arenas_open[AR_W-1:0]] <= 1'b1;
            arenas_open <= arenas_open + OPEN_W'(1);
            opened <= 1'b1;
            state  <= S_WINIT;
          end
        end
        S_WINIT: begin
          pv    <= 1'b0;
          cur   <= heads[cur_ar];
          cv    <= head_valid[cur_ar];
          steps <= '0;
          state <= S_WTEST;
        end
        S_WTEST: begin
          if (cv && !steps[LIMIT_W-1]) begin
            state <= S_WREAD;
          end else begin
            state <= opened ? S_FINISH : S_ARENA;
          end
        end
        S_WREAD: begin
          if (fits) begin
            if (split) begin
              r_slot <= cur + SLOT_W'(HDR_SLOTS) + need[OFF_W-1:ALIGN_W];
              state  <= S_TAKE_B;
            end else begin
              new_has  <= rd_hdr.has_link;
              new_link <= rd_hdr.link;
              state    <= S_TLINK;
            end
          end else begin
            pv    <= 1'b1;
            prev  <= cur;
            cv    <= rd_hdr.has_link;
            cur   <= rd_hdr.link;
            steps <= steps + LIMIT_W'(1);
            state <= S_WTEST;
          end
        end
        S_TAKE_B: begin
          new_has  <= 1'b1;
          new_link <= r_slot;
          state    <= S_TLINK;
        end
        S_TLINK: begin
          if (pv) begin
            state <= S_TPREV;
          end else begin
            heads[cur_ar]      <= new_link;
            head_valid[cur_ar] <= new_has;
            state <= S_AOK;
          end
        end
        S_TPREV: state <= S_AOK;
        S_AOK: begin
          res_status <= ST_OK;
          res_ar     <= cur_ar;
          res_off    <= OFF_W'({cur, {ALIGN_W{1'b0}}}) + OFF_W'(HEADER_BYTES);
          if (move) begin
            res_cb <= old_size;
            state  <= S_FCHECK;
          end else begin
            state  <= S_FINISH;
          end
        end
        S_FCHECK: begin
          cur_ar <= ar_r;
          if (ptr_ok) begin
            state <= S_FREAD;
          end else begin
            res_status <= move ? ST_OK : ST_INVALID;
            state <= S_FINISH;
          end
        end
        S_FREAD: begin
          if (rd_hdr.is_free) begin
            res_status <= move ? ST_OK : ST_DOUBLE;
            state <= S_FINISH;
          end else begin
            heads[cur_ar]      <= h_slot;
            head_valid[cur_ar] <= 1'b1;
            cur   <= h_slot;
            cv    <= 1'b1;
            steps <= '0;
            state <= S_OTEST;
          end
        end
        S_OTEST: begin
          if (cv && !steps[LIMIT_W-1]) begin
            state <= S_OREAD;
          end else begin
            res_status <= move ? ST_OK : ST_FREED;
            state <= S_FINISH;
          end
        end
        S_OREAD: begin
          // end of this entry less one header, as it stands when its pass begins, in slots
          end_slot <= {1'b0, cur} + {1'b0, rd_hdr.size[OFF_W-1:ALIGN_W]};
          slot     <= cur;
          nv       <= rd_hdr.has_link;
          nx       <= rd_hdr.link;
          in_steps <= '0;
          state    <= S_ITEST;
        end
        S_ITEST: begin
          state <= (nv && !in_steps[LIMIT_W-1]) ? S_IREAD : S_ONEXT;
        end
        S_IREAD: begin
          n_size <= rd_hdr.size;
          n_has  <= rd_hdr.has_link;
          n_link <= rd_hdr.link;
          if (match) begin
            state <= S_MERGE_C;
          end else begin
            // slot moves on; its link fields are the ones just read
            slot     <= nx;
            nv       <= rd_hdr.has_link;
            nx       <= rd_hdr.link;
            in_steps <= in_steps + LIMIT_W'(1);
            state    <= S_ITEST;
          end
        end
        S_MERGE_C:  state <= S_MERGE_SR;
        S_MERGE_SR: state <= S_MERGE_S;
        S_MERGE_S: begin
          nv       <= n_has;
          nx       <= n_link;
          in_steps <= in_steps + LIMIT_W'(1);
          state    <= S_ITEST;
        end
        S_ONEXT: begin
          cv    <= rd_hdr.has_link;
          cur   <= rd_hdr.link;
          steps <= steps + LIMIT_W'(1);
          state <= S_OTEST;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            result_arena  <= res_ar;
            result_offset <= res_off;
            copy_bytes    <= res_cb;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/ffa_checker.sv =====
// Scoreboard for the first-fit arena allocator: watches both channels, keeps its own
// copy of the header store and free lists, predicts each response and compares.
// Depends on ffa_pkg.
module ffa_checker
  import ffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [15:0]       request_size,
  input  logic              pointer_present,
  input  logic [AR_W-1:0]   arena_index,
  input  logic [OFF_W-1:0]  payload_offset,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        status,
  input  logic [AR_W-1:0]   result_arena,
  input  logic [OFF_W-1:0]  result_offset,
  input  logic [OFF_W-1:0]  copy_bytes,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = MAX_ARENAS * ARENA_BYTES;

  typedef struct {
    int unsigned size;
    int unsigned link;
    bit          is_free;
    bit          has_link;
    bit          written;
  } blk_hdr_t;

  typedef struct {
    logic [2:0]       st;
    logic [AR_W-1:0]  ar;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] cb;
  } resp_t;

  blk_hdr_t    hdrs[SLOTS];
  int unsigned heads[MAX_ARENAS];
  bit          head_ok[MAX_ARENAS];
  int unsigned n_open;
  resp_t       resp_q[$];

  function automatic int unsigned pos(int unsigned ar, int unsigned off);
    return (ar % MAX_ARENAS) * ARENA_BYTES + (off % ARENA_BYTES);
  endfunction

  // first-fit walk of one arena, split when enough spare remains
  function automatic bit carve(int unsigned ar, int unsigned need, output int unsigned hpos);
    bit pv, cv;
    int unsigned prev, cur, steps, b, r, rb, p;
    pv = 0; cv = head_ok[ar]; prev = 0; cur = heads[ar]; steps = 0; hpos = 0;
    while (cv && steps < ARENA_BYTES) begin
      b = pos(ar, cur);
      if (hdrs[b].is_free && hdrs[b].size >= need) begin
        if (hdrs[b].size >= need + SPLIT_SPARE) begin
          r = cur + HEADER_BYTES + need;
          rb = pos(ar, r);
          hdrs[rb].size = hdrs[b].size - need - HEADER_BYTES;
          hdrs[rb].is_free = 1;
          hdrs[rb].has_link = hdrs[b].has_link;
          hdrs[rb].link = hdrs[b].link;
          hdrs[rb].written = 1;
          hdrs[b].size = need;
          hdrs[b].has_link = 1;
          hdrs[b].link = r;
        end
        hdrs[b].is_free = 0;
        if (pv) begin
          p = pos(ar, prev);
          hdrs[p].has_link = hdrs[b].has_link;
          hdrs[p].link = hdrs[b].link;
        end else begin
          head_ok[ar] = hdrs[b].has_link;
          heads[ar] = hdrs[b].link;
        end
        hpos = cur;
        return 1;
      end
      pv = 1;
      prev = cur;
      cv = hdrs[b].has_link;
      cur = hdrs[b].link;
      steps++;
    end
    return 0;
  endfunction

  function automatic bit grab(int unsigned size, output int unsigned ra, output int unsigned ro);
    int unsigned need, i, h, b;
    ra = 0; ro = 0;
    if (size == 0) return 0;
    need = ((size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    if (need > FULL_SIZE) return 0;
    for (i = n_open; i > 0; i--) begin
      if (carve(i - 1, need, h)) begin
        ra = i - 1;
        ro = h + HEADER_BYTES;
        return 1;
      end
    end
    if (n_open >= MAX_ARENAS) return 0;
    i = n_open;
    n_open++;
    b = pos(i, 0);
    hdrs[b].size = FULL_SIZE;
    hdrs[b].is_free = 1;
    hdrs[b].has_link = 0;
    hdrs[b].link = 0;
    hdrs[b].written = 1;
    heads[i] = 0;
    head_ok[i] = 1;
    if (!carve(i, need, h)) return 0;
    ra = i;
    ro = h + HEADER_BYTES;
    return 1;
  endfunction

  function automatic bit addr_ok(int unsigned ar, int unsigned off);
    if (ar >= n_open || ar >= MAX_ARENAS) return 0;
    if (off >= ARENA_BYTES || off < HEADER_BYTES) return 0;
    return hdrs[pos(ar, off - HEADER_BYTES)].written;
  endfunction

  // push onto list head, then the nested merge pass
  function automatic logic [2:0] release_blk(int unsigned ar, int unsigned off);
    int unsigned h, cur, os, ci, ni, si, endp, slot, is, nx;
    bit cv, nv;
    if (!addr_ok(ar, off)) return ST_INVALID;
    h = off - HEADER_BYTES;
    ci = pos(ar, h);
    if (hdrs[ci].is_free) return ST_DOUBLE;
    hdrs[ci].is_free = 1;
    hdrs[ci].has_link = head_ok[ar];
    hdrs[ci].link = heads[ar];
    heads[ar] = h;
    head_ok[ar] = 1;
    cv = 1; cur = h; os = 0;
    while (cv && os < ARENA_BYTES) begin
      ci = pos(ar, cur);
      endp = cur + HEADER_BYTES + hdrs[ci].size;
      slot = cur; is = 0;
      nv = hdrs[ci].has_link;
      nx = hdrs[ci].link;
      while (nv && is < ARENA_BYTES) begin
        ni = pos(ar, nx);
        if (nx + HEADER_BYTES == endp) begin
          si = pos(ar, slot);
          hdrs[ci].size = hdrs[ci].size + hdrs[ni].size + HEADER_BYTES;
          hdrs[si].has_link = hdrs[ni].has_link;
          hdrs[si].link = hdrs[ni].link;
        end else begin
          slot = nx;
        end
        nv = hdrs[pos(ar, slot)].has_link;
        nx = hdrs[pos(ar, slot)].link;
        is++;
      end
      cv = hdrs[ci].has_link;
      cur = hdrs[ci].link;
      os++;
    end
    return ST_FREED;
  endfunction

  function automatic resp_t serve(logic [1:0] op, int unsigned size, bit pp,
                                  int unsigned ar, int unsigned off);
    resp_t r;
    int unsigned ra, ro, cb, need, old;
    logic [2:0] st;
    logic [2:0] dummy;
    st = ST_NULL; ra = 0; ro = 0; cb = 0;
    if (op == OP_ALLOC) begin
      if (grab(size, ra, ro)) st = ST_OK;
    end else if (op == OP_FREE) begin
      if (pp) st = release_blk(ar, off);
    end else if (op == OP_REALLOC) begin
      if (!pp) begin
        if (grab(size, ra, ro)) st = ST_OK;
      end else if (!addr_ok(ar, off)) begin
        st = ST_INVALID;
      end else if (size == 0) begin
        st = release_blk(ar, off);
      end else begin
        need = ((size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        old = hdrs[pos(ar, off - HEADER_BYTES)].size;
        if (need <= old) begin
          st = ST_OK;
          ra = ar;
          ro = off;
        end else if (grab(size, ra, ro)) begin
          st = ST_OK;
          cb = old;
          dummy = release_blk(ar, off);
        end
      end
    end
    if (st != ST_OK) begin
      ra = 0; ro = 0; cb = 0;
    end
    r.st = st;
    r.ar = ra[AR_W-1:0];
    r.off = ro[OFF_W-1:0];
    r.cb = cb[OFF_W-1:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    resp_t exp_r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) hdrs[i] = '{0, 0, 0, 0, 0};
      for (int i = 0; i < MAX_ARENAS; i++) begin
        heads[i] = 0;
        head_ok[i] = 0;
      end
      n_open = 0;
      resp_q.delete();
    end else begin
      if (in_valid && in_ready)
        resp_q.push_back(serve(opcode, request_size, pointer_present,
                               arena_index, payload_offset));
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected beat: status %0d arena %0d offset %0d copy %0d",
                     status, result_arena, result_offset, copy_bytes);
          errors++;
        end else begin
          exp_r = resp_q.pop_front();
          if (status !== exp_r.st || result_arena !== exp_r.ar ||
              result_offset !== exp_r.off || copy_bytes !== exp_r.cb) begin
            if (errors < 10)
              $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       exp_r.st, exp_r.ar, exp_r.off, exp_r.cb,
                       status, result_arena, result_offset, copy_bytes);
            errors++;
          end
        end
      end
    end
    pending = resp_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the allocator testbench: clock, reset, request stimulus and verdict.
// Depends on ffa_pkg, first_fit_arena_allocator and ffa_checker.
module tb_top
  import ffa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 800000;

  typedef struct {
    logic [AR_W-1:0]  ar;
    logic [OFF_W-1:0] off;
  } addr_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        opcode = OP_ALLOC;
  logic [15:0]       request_size = 0;
  logic              pointer_present = 0;
  logic [AR_W-1:0]   arena_index = 0;
  logic [OFF_W-1:0]  payload_offset = 0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [2:0]        status;
  logic [AR_W-1:0]   result_arena;
  logic [OFF_W-1:0]  result_offset;
  logic [OFF_W-1:0]  copy_bytes;
  int                errors, pending;

  int    sent = 0, answered = 0, stall = 0, max_ar = -1;
  bit    steady = 0;
  addr_t last_addr, known[$], live[$];

  first_fit_arena_allocator dut (.*);

  ffa_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // track returned addresses so most pointer requests point at written headers
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      answered++;
      if (status == ST_OK) begin
        last_addr = '{result_arena, result_offset};
        known.push_back(last_addr);
        live.push_back(last_addr);
        if (int'(result_arena) > max_ar) max_ar = result_arena;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
    else stall++;
    if (stall >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [15:0] size, logic pp,
                      logic [AR_W-1:0] ar, logic [OFF_W-1:0] off);
    in_valid <= 1;
    opcode <= op;
    request_size <= size;
    pointer_present <= pp;
    arena_index <= ar;
    payload_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (answered != sent) @(posedge clk);
  endtask

  task automatic one(logic [1:0] op, logic [15:0] size, logic pp,
                     logic [AR_W-1:0] ar, logic [OFF_W-1:0] off);
    send(op, size, pp, ar, off);
    drain();
  endtask

  task automatic pick(output addr_t a, input bit take);
    int k;
    if (live.size() > 0 && $urandom_range(99) < 70) begin
      k = $urandom_range(live.size() - 1);
      a = live[k];
      if (take) live.delete(k);
    end else begin
      a = known[$urandom_range(known.size() - 1)];
    end
  endtask

  task automatic random_item();
    int    r;
    addr_t a;
    logic [15:0] size;
    r = $urandom_range(99);
    case ($urandom_range(19))
      0:       size = 16'($urandom());
      1, 2, 3: size = 16'($urandom_range(2048, 257));
      default: size = 16'($urandom_range(256, 1));
    endcase
    if (r < 45) begin
      send(OP_ALLOC, size, 1'($urandom()), AR_W'($urandom()), OFF_W'($urandom()));
    end else if (r < 75) begin
      case ($urandom_range(19))
        0: send(OP_FREE, 16'($urandom()), 0, AR_W'($urandom()), OFF_W'($urandom()));
        1: send(OP_FREE, 16'($urandom()), 1, AR_W'($urandom_range(max_ar)),
                OFF_W'($urandom_range(23)));
        default: begin
          pick(a, 1);
          send(OP_FREE, 16'($urandom()), 1, a.ar, a.off);
        end
      endcase
    end else if (r < 95) begin
      case ($urandom_range(9))
        0: send(OP_REALLOC, size, 0, AR_W'($urandom()), OFF_W'($urandom()));
        1: begin
          pick(a, 1);
          send(OP_REALLOC, 0, 1, a.ar, a.off);
        end
        default: begin
          pick(a, 1);
          send(OP_REALLOC, size, 1, a.ar, a.off);
        end
      endcase
    end else begin
      send(OP_UNUSED, 16'($urandom()), 1'($urandom()), AR_W'($urandom()),
           OFF_W'($urandom()));
    end
  endtask

  initial begin
    addr_t a, big[$];
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: size edges, null and invalid pointers, double free, realloc paths, unused opcode, arena exhaustion
    one(OP_ALLOC, 0, 0, 0, 0);
    one(OP_ALLOC, 16'(FULL_SIZE + 1), 0, 0, 0);
    one(OP_ALLOC, 16'hffff, 0, 0, 0);
    one(OP_FREE, 0, 0, 0, 0);
    one(OP_FREE, 0, 1, 3, OFF_W'(HEADER_BYTES));
    one(OP_ALLOC, 100, 0, 0, 0);
    a = last_addr;
    one(OP_FREE, 0, 1, 0, 0);
    one(OP_REALLOC, 50, 1, a.ar, a.off);
    one(OP_REALLOC, 300, 1, a.ar, a.off);
    one(OP_FREE, 0, 1, a.ar, a.off);
    one(OP_REALLOC, 500, 1, a.ar, a.off);
    one(OP_REALLOC, 40, 0, 0, 0);
    one(OP_REALLOC, 0, 1, last_addr.ar, last_addr.off);
    one(OP_UNUSED, 16'hffff, 1, 3, 13'h1fff);
    for (int i = 0; i < 3; i++) begin
      one(OP_ALLOC, 16'(FULL_SIZE), 0, 0, 0);
      big.push_back(last_addr);
    end
    one(OP_ALLOC, 16'(FULL_SIZE), 0, 0, 0);
    foreach (big[i]) one(OP_FREE, 0, 1, big[i].ar, big[i].off);
    one(OP_ALLOC, 1, 0, 0, 0);
    one(OP_ALLOC, 8, 0, 0, 0);

    for (int n = 0; n < 750; n++) begin
      steady = (n >= 300 && n < 420);
      random_item();
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
